[rtl/pli_pkg.sv]
// ----------------------------------------------------------------------------
// Positional list package
// Shared widths, operation and status codes, and the per-cell command word.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int POS_W            = 7;
    localparam int VALUE_W          = 16;
    localparam int LENGTH_W         = 7;
    localparam int DEPTH_DEF        = 64;
    localparam int DATA_WIDTH_DEF   = 16;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } t_cell_cmd;

endpackage

[rtl/pli_cell.sv]
// ----------------------------------------------------------------------------
// Positional list cell
// One list slot: holds, loads the inserted word, or takes a neighbor's word.
// ----------------------------------------------------------------------------
module pli_cell #(
    parameter int DATA_WIDTH = pli_pkg::DATA_WIDTH_DEF,
    parameter int SLOT_W     = 8,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  pli_pkg::t_cell_cmd    i_cmd,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_pick
);

    localparam logic [SLOT_W-1:0] IDX = SLOT_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_cmd.do_insert) begin
            if (IDX == i_slot) begin
                n_data = i_value;
            end else if (IDX > i_slot) begin
                n_data = i_left;
            end
        end else if (i_cmd.do_remove) begin
            if (IDX >= i_slot) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_pick = (IDX == i_slot) ? r_data : '0;

endmodule

[rtl/positional_list_insert_remove.sv]
// ----------------------------------------------------------------------------
// Positional list with insert and remove at a position
// Ordered list of up to DEPTH words in a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  command   i_start / o_busy        i_kind, i_position, i_value
//  result    o_valid (strobe)        o_status, o_removed_value, o_length
//
//  A command is taken on any edge with i_start high; o_busy stays low.
//  All cells compare their slot with the position and shift in the same
//  edge, so one command completes per cycle; the result strobes in the
//  cycle after acceptance. Reset empties the list at once; no clearing pass.
//  The receiver cannot stall, so results never back up.
// ----------------------------------------------------------------------------
module positional_list_insert_remove #(
    parameter int DEPTH      = pli_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = pli_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_kind,
    input  logic [pli_pkg::POS_W-1:0]    i_position,
    input  logic [pli_pkg::VALUE_W-1:0]  i_value,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [pli_pkg::VALUE_W-1:0]  o_removed_value,
    output logic [pli_pkg::LENGTH_W-1:0] o_length
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SLOT_W = ((CNT_W > pli_pkg::POS_W) ? CNT_W : pli_pkg::POS_W) + 1;
    localparam int EXT_W  = (DATA_WIDTH > pli_pkg::VALUE_W) ? DATA_WIDTH : pli_pkg::VALUE_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic                       r_valid;
    pli_pkg::t_status           r_status;
    pli_pkg::t_status           n_status;
    logic [pli_pkg::VALUE_W-1:0] r_removed;
    logic [pli_pkg::VALUE_W-1:0] n_removed;

    logic                       accept;
    logic [SLOT_W-1:0]          pos_ext;
    logic [SLOT_W-1:0]          cnt_ext;
    logic [SLOT_W-1:0]          slot;
    logic                       pos_zero;
    pli_pkg::t_cell_cmd         cmd;
    logic [EXT_W-1:0]           value_ext;
    logic [EXT_W-1:0]           picked_ext;
    logic [SLOT_W-1:0]          length_ext;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] cell_pick [DEPTH];
    logic [DATA_WIDTH-1:0] picked;

    assign accept    = i_start && !o_busy;
    assign pos_ext   = SLOT_W'(i_position);
    assign cnt_ext   = SLOT_W'(r_count);
    assign pos_zero  = (i_position == '0);
    assign slot      = pos_ext - SLOT_W'(1);
    assign value_ext = EXT_W'(i_value);

    always_comb begin
        n_status      = pli_pkg::ST_DONE;
        cmd.do_insert = 1'b0;
        cmd.do_remove = 1'b0;
        n_count       = r_count;
        if (i_kind == pli_pkg::KIND_INSERT) begin
            if (r_count == FULL_CNT) begin
                n_status = pli_pkg::ST_FULL;
            end else if (pos_zero || (slot > cnt_ext)) begin
                n_status = pli_pkg::ST_RANGE;
            end else begin
                cmd.do_insert = accept;
                n_count       = r_count + CNT_W'(1);
            end
        end else begin
            if (r_count == '0) begin
                n_status = pli_pkg::ST_EMPTY;
            end else if (pos_zero || (pos_ext > cnt_ext)) begin
                n_status = pli_pkg::ST_RANGE;
            end else begin
                cmd.do_remove = accept;
                n_count       = r_count - CNT_W'(1);
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left;
        logic [DATA_WIDTH-1:0] right;
        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_inner_l
            assign left = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right = cell_data[g];
        end else begin : g_inner_r
            assign right = cell_data[g+1];
        end
        pli_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .SLOT_W     (SLOT_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_slot  (slot),
            .i_value (value_ext[DATA_WIDTH-1:0]),
            .i_left  (left),
            .i_right (right),
            .o_data  (cell_data[g]),
            .o_pick  (cell_pick[g])
        );
    end

    always_comb begin
        picked = '0;
        for (int k = 0; k < DEPTH; k++) begin
            picked = picked | cell_pick[k];
        end
    end

    assign picked_ext = EXT_W'(picked);
    assign n_removed  = cmd.do_remove ? picked_ext[pli_pkg::VALUE_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
        if (accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign length_ext      = SLOT_W'(r_count);
    assign o_busy          = 1'b0;
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_length        = length_ext[pli_pkg::LENGTH_W-1:0];

endmodule

[rtl/pli_checker.sv]
// ----------------------------------------------------------------------------
// Positional list port checker
// Watches the top level's ports for result timing and status consistency.
// ----------------------------------------------------------------------------
module pli_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_start,
    input logic                         o_busy,
    input logic                         i_kind,
    input logic                         o_valid,
    input logic [1:0]                   o_status,
    input logic [pli_pkg::VALUE_W-1:0]  o_removed_value,
    input logic [pli_pkg::LENGTH_W-1:0] o_length
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_valid)
        else $error("accepted word gave no result");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !(i_start && !o_busy)) |=> !o_valid)
        else $error("result without accepted word");

    a_insert_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_kind) == pli_pkg::KIND_INSERT)) |-> (o_removed_value == '0))
        else $error("insert reported a removed value");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == pli_pkg::ST_EMPTY)) |-> (o_length == '0))
        else $error("empty status with nonzero length");

    a_full_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == pli_pkg::ST_FULL))
            |-> ($past(i_kind) == pli_pkg::KIND_INSERT))
        else $error("full status on a remove");

endmodule

bind positional_list_insert_remove pli_checker u_pli_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .i_kind          (i_kind),
    .o_valid         (o_valid),
    .o_status        (o_status),
    .o_removed_value (o_removed_value),
    .o_length        (o_length)
);

[dv/positional_list_insert_remove_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list testbench
// Drives insert and remove commands through the start/busy port, keeps a
// shadow copy of the list and checks status, removed word and length of
// every strobed result against it, in order.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_tb;

    localparam int LIST_DEPTH = pli_pkg::DEPTH_DEF;
    localparam logic [pli_pkg::VALUE_W-1:0] DATA_MASK =
        pli_pkg::VALUE_W'((64'd1 << pli_pkg::DATA_WIDTH_DEF) - 1);

    typedef struct {
        pli_pkg::t_status              status;
        logic [pli_pkg::VALUE_W-1:0]   removed;
        logic [pli_pkg::LENGTH_W-1:0]  length;
    } t_list_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_start;
    logic                          o_busy;
    logic                          i_kind;
    logic [pli_pkg::POS_W-1:0]     i_position;
    logic [pli_pkg::VALUE_W-1:0]   i_value;
    logic                          o_valid;
    logic [1:0]                    o_status;
    logic [pli_pkg::VALUE_W-1:0]   o_removed_value;
    logic [pli_pkg::LENGTH_W-1:0]  o_length;

    logic [pli_pkg::VALUE_W-1:0]   shadow_cells [LIST_DEPTH];
    int                            list_count;
    t_list_result                  pending_results [$];

    int n_mismatch;
    int n_checked;
    int n_insert_ok;
    int n_remove_ok;
    int n_full;
    int n_empty;
    int n_range;
    int max_length;

    positional_list_insert_remove #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (pli_pkg::DATA_WIDTH_DEF)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_kind          (i_kind),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_length        (o_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_list_result apply_list_op(
        input logic                        kind,
        input logic [pli_pkg::POS_W-1:0]   pos,
        input logic [pli_pkg::VALUE_W-1:0] val);
        t_list_result r;
        int           p;
        int           i;
        p         = int'(pos);
        r.removed = '0;
        if (kind == pli_pkg::KIND_INSERT) begin
            if (list_count >= LIST_DEPTH) begin
                r.status = pli_pkg::ST_FULL;
            end else if (p == 0 || p > list_count + 1) begin
                r.status = pli_pkg::ST_RANGE;
            end else begin
                for (i = list_count; i >= p; i--)
                    shadow_cells[i] = shadow_cells[i-1];
                shadow_cells[p-1] = val & DATA_MASK;
                list_count++;
                r.status = pli_pkg::ST_DONE;
            end
        end else begin
            if (list_count == 0) begin
                r.status = pli_pkg::ST_EMPTY;
            end else if (p == 0 || p > list_count) begin
                r.status = pli_pkg::ST_RANGE;
            end else begin
                r.removed = shadow_cells[p-1];
                for (i = p - 1; i + 1 < list_count; i++)
                    shadow_cells[i] = shadow_cells[i+1];
                list_count--;
                r.status = pli_pkg::ST_DONE;
            end
        end
        r.length = pli_pkg::LENGTH_W'(list_count);
        return r;
    endfunction

    task automatic send_word(input logic kind, input logic [pli_pkg::POS_W-1:0] pos,
                             input logic [pli_pkg::VALUE_W-1:0] val, input bit gaps_on);
        t_list_result r;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_start    <= 1'b0;
            i_kind     <= 1'($urandom);
            i_position <= pli_pkg::POS_W'($urandom);
            i_value    <= pli_pkg::VALUE_W'($urandom);
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_value    <= val;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        r = apply_list_op(kind, pos, val);
        pending_results.push_back(r);
        case (r.status)
            pli_pkg::ST_DONE:
                if (kind == pli_pkg::KIND_INSERT) n_insert_ok++; else n_remove_ok++;
            pli_pkg::ST_FULL:  n_full++;
            pli_pkg::ST_EMPTY: n_empty++;
            default:           n_range++;
        endcase
        if (list_count > max_length) max_length = list_count;
    endtask

    task automatic send_random(input int insert_pct, input int noise_pct, input bit gaps_on);
        logic                      kind;
        logic [pli_pkg::POS_W-1:0] pos;
        kind = ($urandom_range(0, 99) < insert_pct) ? pli_pkg::KIND_INSERT
                                                    : pli_pkg::KIND_REMOVE;
        if ($urandom_range(0, 99) < noise_pct)
            pos = pli_pkg::POS_W'($urandom_range(0, 127));
        else if (kind == pli_pkg::KIND_INSERT)
            pos = pli_pkg::POS_W'((list_count == LIST_DEPTH)
                                  ? $urandom_range(1, LIST_DEPTH)
                                  : $urandom_range(1, list_count + 1));
        else
            pos = pli_pkg::POS_W'((list_count == 0) ? $urandom_range(1, LIST_DEPTH)
                                                    : $urandom_range(1, list_count));
        send_word(kind, pos, pli_pkg::VALUE_W'($urandom), gaps_on);
    endtask

    task automatic wait_results_drained();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_list_result exp_r;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("%0t: result word with nothing expected: st=%0d rv=%h len=%0d",
                             $time, o_status, o_removed_value, o_length);
            end else begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (o_status !== exp_r.status || o_removed_value !== exp_r.removed ||
                    o_length !== exp_r.length) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%0t: mismatch exp st=%0d rv=%h len=%0d got st=%0d rv=%h len=%0d",
                                 $time, exp_r.status, exp_r.removed, exp_r.length,
                                 o_status, o_removed_value, o_length);
                end
            end
        end
    end

    task automatic test_basic_ops();
        send_word(pli_pkg::KIND_REMOVE, 7'd1,   16'h1234, 1'b0);
        send_word(pli_pkg::KIND_REMOVE, 7'd0,   16'h0000, 1'b0);
        send_word(pli_pkg::KIND_INSERT, 7'd0,   16'hFFFF, 1'b0);
        send_word(pli_pkg::KIND_INSERT, 7'd2,   16'h0001, 1'b0);
        send_word(pli_pkg::KIND_INSERT, 7'd127, 16'h8000, 1'b0);
        send_word(pli_pkg::KIND_INSERT, 7'd1,   16'h0000, 1'b0);
        send_word(pli_pkg::KIND_INSERT, 7'd2,   16'hFFFF, 1'b1);
        send_word(pli_pkg::KIND_INSERT, 7'd1,   16'hA5A5, 1'b0);
        send_word(pli_pkg::KIND_INSERT, 7'd2,   16'h5A5A, 1'b1);
        send_word(pli_pkg::KIND_REMOVE, 7'd0,   16'hFFFF, 1'b0);
        send_word(pli_pkg::KIND_REMOVE, 7'd5,   16'h0000, 1'b0);
        send_word(pli_pkg::KIND_REMOVE, 7'd127, 16'h0000, 1'b0);
        send_word(pli_pkg::KIND_REMOVE, 7'd64,  16'h0000, 1'b0);
        send_word(pli_pkg::KIND_REMOVE, 7'd2,   16'h0000, 1'b1);
        send_word(pli_pkg::KIND_REMOVE, 7'd3,   16'h0000, 1'b0);
        send_word(pli_pkg::KIND_REMOVE, 7'd1,   16'h0000, 1'b0);
        send_word(pli_pkg::KIND_REMOVE, 7'd1,   16'h0000, 1'b1);
        send_word(pli_pkg::KIND_REMOVE, 7'd1,   16'h0000, 1'b0);
    endtask

    task automatic test_fill_and_drain();
        while (list_count < LIST_DEPTH)
            send_random(100, 0, 1'b1);
        send_word(pli_pkg::KIND_INSERT, 7'd1,   16'h7FFF, 1'b0);
        send_word(pli_pkg::KIND_INSERT, 7'd65,  16'h0F0F, 1'b0);
        send_word(pli_pkg::KIND_INSERT, 7'd0,   16'hF0F0, 1'b1);
        send_word(pli_pkg::KIND_INSERT, 7'd127, 16'hFFFF, 1'b0);
        send_word(pli_pkg::KIND_REMOVE, 7'd65,  16'h0000, 1'b0);
        send_word(pli_pkg::KIND_REMOVE, 7'd127, 16'h0000, 1'b0);
        send_word(pli_pkg::KIND_REMOVE, 7'd64,  16'h0000, 1'b1);
        send_word(pli_pkg::KIND_INSERT, 7'd64,  16'hC3C3, 1'b0);
        while (list_count > 0)
            send_random(0, 0, 1'b1);
        send_word(pli_pkg::KIND_REMOVE, 7'd64,  16'h0000, 1'b0);
        send_word(pli_pkg::KIND_INSERT, 7'd1,   16'hFFFF, 1'b0);
    endtask

    task automatic test_wait_for_results();
        wait_results_drained();
        repeat (3) send_random(50, 10, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_random_mix();
        int blk;
        int n;
        int bias;
        bit gaps_on;
        for (blk = 0; blk < 10; blk++) begin
            case ($urandom_range(0, 4))
                0:       bias = 85;
                1:       bias = 15;
                2:       bias = 60;
                3:       bias = 40;
                default: bias = 50;
            endcase
            gaps_on = ($urandom_range(0, 2) != 0);
            for (n = 0; n < 100; n++)
                send_random(bias, 10, gaps_on);
        end
    endtask

    task automatic test_back_to_back();
        int n;
        for (n = 0; n < 60; n++)
            send_random(70, 10, 1'b0);
        for (n = 0; n < 60; n++)
            send_random(30, 10, 1'b0);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_start    <= 1'b0;
        i_kind     <= pli_pkg::KIND_INSERT;
        i_position <= '0;
        i_value    <= '0;
        list_count  = 0;
        n_mismatch  = 0;
        n_checked   = 0;
        n_insert_ok = 0;
        n_remove_ok = 0;
        n_full      = 0;
        n_empty     = 0;
        n_range     = 0;
        max_length  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_fill_and_drain();
        test_wait_for_results();
        test_random_mix();
        test_back_to_back();

        wait_results_drained();
        repeat (5) @(posedge i_clk);
        if (pending_results.size() != 0) n_mismatch++;

        $display("checked %0d results: %0d inserts, %0d removes, %0d full, %0d empty, %0d range",
                 n_checked, n_insert_ok, n_remove_ok, n_full, n_empty, n_range);
        $display("longest list %0d of %0d entries, %0d mismatches",
                 max_length, LIST_DEPTH, n_mismatch);
        if (n_mismatch == 0) begin
            $display("positional_list_insert_remove_tb: PASS");
        end else begin
            $display("positional_list_insert_remove_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #1ms;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("positional_list_insert_remove_tb: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/pli_pkg.sv
rtl/pli_cell.sv
rtl/positional_list_insert_remove.sv
rtl/pli_checker.sv
dv/positional_list_insert_remove_tb.sv
